// File: design/ghe_pkg.sv
`default_nettype none

package ghe_pkg;

    localparam int COUNT_BITS = 23;
    localparam int BINS       = 256;
    localparam int BIN_BITS   = $clog2(BINS);
    localparam int PIX_BITS   = 8;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [BIN_BITS-1:0]   bin_t;
    typedef logic [PIX_BITS-1:0]   pix_t;

    localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};

    // Input mode codes
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    // Result kind codes
    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_READ    = 1'b1;

    // Read port request to the bin store
    typedef struct packed {
        logic en;
        logic clr;
        bin_t addr;
    } store_rd_t;

    // Write port request to the bin store
    typedef struct packed {
        logic   en;
        bin_t   addr;
        count_t data;
    } store_wr_t;

endpackage

`default_nettype wire

// File: design/ghe_if.sv
`default_nettype none

interface ghe_in_if
    import ghe_pkg::*;
();
    logic valid;
    logic ready;
    logic mode;
    pix_t pixel;
    logic last;

    modport source (output valid, output mode, output pixel, output last, input ready);
    modport sink   (input valid, input mode, input pixel, input last, output ready);
endinterface

interface ghe_out_if
    import ghe_pkg::*;
();
    logic   valid;
    logic   ready;
    logic   kind;
    pix_t   min_pixel;
    pix_t   max_pixel;
    count_t min_count;
    count_t max_count;
    count_t bin_count;

    modport source (output valid, output kind, output min_pixel, output max_pixel,
                    output min_count, output max_count, output bin_count, input ready);
    modport sink   (input valid, input kind, input min_pixel, input max_pixel,
                    input min_count, input max_count, input bin_count, output ready);
endinterface

`default_nettype wire

// File: design/ghe_bin_store.sv
`default_nettype none

module ghe_bin_store
    import ghe_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire store_rd_t rd,
    input  wire store_wr_t wr,
    output count_t         rd_count
);

    count_t          mem [BINS];
    logic [BINS-1:0] valid_reg;

    count_t rd_data_reg;
    logic   rd_valid_reg;
    logic   byp_hit_reg;
    count_t byp_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    // Bypass a write that lands on the entry being read in the same cycle
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            byp_hit_reg  <= wr.en && (wr.addr == rd.addr);
            byp_data_reg <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (rd.en)
            begin
                rd_valid_reg <= rd.clr ? 1'b0 : valid_reg[rd.addr];
            end
            if (rd.clr)
            begin
                valid_reg <= '0;
            end
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
        end
    end

    always_comb
    begin
        if (byp_hit_reg)
        begin
            rd_count = byp_data_reg;
        end
        else if (rd_valid_reg)
        begin
            rd_count = rd_data_reg;
        end
        else
        begin
            rd_count = '0;
        end
    end

endmodule

`default_nettype wire

// File: design/gray_histogram_with_extrema.sv
// Gray-level histogram with pixel and count extrema.
//
// Channel pix carries one transaction per pixel (mode = pixel) or per bin
// read (mode = read). Channel res carries the results: a frame summary after
// the pixel marked last, and one answer per bin read. Pixels without the
// last mark give no result.
//
// Pixels and reads are taken one per cycle unless a read answer waits for a
// free output register. Each bin update is a read-modify-write of a 256 x 23
// synchronous memory with a registered read; a write to the entry read in the
// same cycle is forwarded. A read answer passes the update stage and then the
// output register. After the last pixel the input is held off while the store
// is scanned one bin per cycle, until the summary enters the output register.
//
// The first pixel of a frame empties all bins at once through per-bin valid
// flags; reset does the same, so no clearing pass is needed. If res stalls,
// a pending read answer or summary holds in the output register and pix
// backs up.
`default_nettype none

module gray_histogram_with_extrema
    import ghe_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    ghe_in_if.sink   pix,
    ghe_out_if.source res
);

    typedef enum logic [1:0] {
        ST_RUN,
        ST_WAIT,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t state_reg;

    // Update stage: item whose memory read is in flight
    logic s1_valid_reg;
    logic s1_read_reg;
    bin_t s1_addr_reg;

    logic frame_open_reg;
    pix_t low_pixel_reg;
    pix_t high_pixel_reg;

    // Scan of the bin store
    logic [BIN_BITS:0] scan_cnt_reg;
    logic              cmp_valid_reg;
    count_t            cnt_min_reg;
    count_t            cnt_max_reg;

    // Output register
    logic   out_valid_reg;
    logic   out_kind_reg;
    pix_t   out_min_pixel_reg;
    pix_t   out_max_pixel_reg;
    count_t out_min_count_reg;
    count_t out_max_count_reg;
    count_t out_bin_count_reg;

    store_rd_t rd;
    store_wr_t wr;
    count_t    base_count;

    logic out_free;
    logic stall;
    logic accept;
    logic pix_accept;
    logic frame_start;
    logic scan_issue;

    ghe_bin_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd       (rd),
        .wr       (wr),
        .rd_count (base_count)
    );

    assign out_free    = !out_valid_reg || res.ready;
    // Hold a read answer in the update stage until the output register frees up
    assign stall       = s1_valid_reg && s1_read_reg && !out_free;
    assign pix.ready   = (state_reg == ST_RUN) && !stall;
    assign accept      = pix.valid && pix.ready;
    assign pix_accept  = accept && (pix.mode == MODE_PIXEL);
    assign frame_start = pix_accept && !frame_open_reg;
    assign scan_issue  = (state_reg == ST_SCAN) && !scan_cnt_reg[BIN_BITS];

    always_comb
    begin
        rd.en   = accept || scan_issue;
        rd.clr  = frame_start;
        rd.addr = accept ? pix.pixel : scan_cnt_reg[BIN_BITS-1:0];

        wr.en   = s1_valid_reg && !s1_read_reg;
        wr.addr = s1_addr_reg;
        wr.data = (base_count == COUNT_MAX) ? base_count : base_count + 1'b1;
    end

    assign res.valid     = out_valid_reg;
    assign res.kind      = out_kind_reg;
    assign res.min_pixel = out_min_pixel_reg;
    assign res.max_pixel = out_max_pixel_reg;
    assign res.min_count = out_min_count_reg;
    assign res.max_count = out_max_count_reg;
    assign res.bin_count = out_bin_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_RUN;
            s1_valid_reg      <= 1'b0;
            s1_read_reg       <= 1'b0;
            s1_addr_reg       <= '0;
            frame_open_reg    <= 1'b0;
            low_pixel_reg     <= '1;
            high_pixel_reg    <= '0;
            scan_cnt_reg      <= '0;
            cmp_valid_reg     <= 1'b0;
            cnt_min_reg       <= COUNT_MAX;
            cnt_max_reg       <= '0;
            out_valid_reg     <= 1'b0;
            out_kind_reg      <= KIND_SUMMARY;
            out_min_pixel_reg <= '0;
            out_max_pixel_reg <= '0;
            out_min_count_reg <= '0;
            out_max_count_reg <= '0;
            out_bin_count_reg <= '0;
        end
        else
        begin
            // Advance the update stage unless a read answer is stuck
            if (!stall)
            begin
                s1_valid_reg <= accept;
                s1_read_reg  <= (pix.mode == MODE_READ);
                s1_addr_reg  <= pix.pixel;
            end

            // Track pixel extrema; a new frame restarts them with this pixel
            if (pix_accept)
            begin
                frame_open_reg <= !pix.last;
                if (frame_start || pix.pixel < low_pixel_reg)
                begin
                    low_pixel_reg <= pix.pixel;
                end
                if (frame_start || pix.pixel > high_pixel_reg)
                begin
                    high_pixel_reg <= pix.pixel;
                end
            end

            // Output register: read answers, summaries, drain when taken
            if (s1_valid_reg && s1_read_reg && out_free)
            begin
                out_valid_reg     <= 1'b1;
                out_kind_reg      <= KIND_READ;
                out_min_pixel_reg <= '0;
                out_max_pixel_reg <= '0;
                out_min_count_reg <= '0;
                out_max_count_reg <= '0;
                out_bin_count_reg <= base_count;
            end
            else if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg     <= 1'b1;
                out_kind_reg      <= KIND_SUMMARY;
                out_min_pixel_reg <= low_pixel_reg;
                out_max_pixel_reg <= high_pixel_reg;
                out_min_count_reg <= cnt_min_reg;
                out_max_count_reg <= cnt_max_reg;
                out_bin_count_reg <= '0;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_RUN:
                begin
                    if (pix_accept && pix.last)
                    begin
                        state_reg <= ST_WAIT;
                    end
                end
                ST_WAIT:
                begin
                    // Last pixel's write lands this cycle; start the scan after it
                    scan_cnt_reg  <= '0;
                    cmp_valid_reg <= 1'b0;
                    cnt_min_reg   <= COUNT_MAX;
                    cnt_max_reg   <= '0;
                    state_reg     <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (scan_issue)
                    begin
                        scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    end
                    cmp_valid_reg <= scan_issue;
                    if (cmp_valid_reg)
                    begin
                        if (base_count < cnt_min_reg)
                        begin
                            cnt_min_reg <= base_count;
                        end
                        if (base_count > cnt_max_reg)
                        begin
                            cnt_max_reg <= base_count;
                        end
                    end
                    else if (scan_cnt_reg[BIN_BITS])
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_RUN;
                    end
                end
                default:
                begin
                    state_reg <= ST_RUN;
                end
            endcase
        end
    end

    // No bin update may land while the store is being scanned
    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !wr.en)
        else $error("bin write during scan");

    // The last pixel of a frame closes the input for the scan
    a_last_closes_input: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_accept && pix.last) |=> !pix.ready)
        else $error("input open after last pixel");

    // A finished scan never reports a minimum above the maximum
    a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (cnt_min_reg <= cnt_max_reg))
        else $error("count minimum above maximum");

endmodule

`default_nettype wire

// File: tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ghe_pkg::*;

    // Run shape: how many pixel/read transactions to send, how many of the last
    // ones go without any idling, how long a quiet spell may last, and how long
    // to watch for stray results at the end. The quiet limit covers the
    // end-of-frame scan of all bins plus the longest stall on either side.
    localparam int ITEM_TARGET    = 1200;
    localparam int CALM_ITEMS     = 150;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int REPORT_LIMIT   = 10;

    // One result transaction as it appears on the res channel.
    typedef struct packed {
        logic   kind;
        pix_t   min_pixel;
        pix_t   max_pixel;
        count_t min_count;
        count_t max_count;
        count_t bin_count;
    } hist_result_t;

    // One row of the directed part. Where known is set, the result is typed in
    // by hand and replaces the predicted one.
    typedef struct {
        logic         mode;
        pix_t         pixel;
        logic         last;
        bit           known;
        hist_result_t want;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 23;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    ghe_in_if  pix_ch ();
    ghe_out_if res_ch ();

    gray_histogram_with_extrema i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix_ch),
        .res   (res_ch)
    );

    always #10 clk = ~clk;

    // Predicted histogram state: bin tallies, pixel extrema of the open frame,
    // and whether a frame is open.
    count_t tally [BINS];
    pix_t   frame_low;
    pix_t   frame_high;
    bit     frame_active;

    hist_result_t expected_results [$];

    int  items_sent  = 0;
    int  frames_sent = 0;
    int  sweeps_done = 0;
    int  errors      = 0;
    int  quiet_cycles = 0;
    bit  calm        = 1'b0;
    pix_t recent_pixel = '0;

    // Directed part: reads after reset, one-pixel frame at the bottom value,
    // stale reads after a frame, reads inside an open frame, clearing at frame
    // start, the extremes 0 and 255, alternating bit patterns, back-to-back hits
    // on one bin, and a read right behind a write to the same bin.
    directed_row_t directed_table [DIRECTED_ROWS] = '{
        '{MODE_READ,  8'd0,   1'b0, 1'b1, '{KIND_READ,    8'd0,  8'd0,   23'd0, 23'd0, 23'd0}},
        '{MODE_READ,  8'd255, 1'b0, 1'b1, '{KIND_READ,    8'd0,  8'd0,   23'd0, 23'd0, 23'd0}},
        '{MODE_PIXEL, 8'd0,   1'b1, 1'b1, '{KIND_SUMMARY, 8'd0,  8'd0,   23'd0, 23'd1, 23'd0}},
        '{MODE_READ,  8'd0,   1'b0, 1'b1, '{KIND_READ,    8'd0,  8'd0,   23'd0, 23'd0, 23'd1}},
        '{MODE_PIXEL, 8'd255, 1'b0, 1'b0, '0},
        '{MODE_READ,  8'd255, 1'b0, 1'b1, '{KIND_READ,    8'd0,  8'd0,   23'd0, 23'd0, 23'd1}},
        '{MODE_READ,  8'd0,   1'b0, 1'b1, '{KIND_READ,    8'd0,  8'd0,   23'd0, 23'd0, 23'd0}},
        '{MODE_PIXEL, 8'd255, 1'b0, 1'b0, '0},
        '{MODE_PIXEL, 8'd0,   1'b0, 1'b0, '0},
        '{MODE_PIXEL, 8'd128, 1'b1, 1'b1, '{KIND_SUMMARY, 8'd0,  8'd255, 23'd0, 23'd2, 23'd0}},
        '{MODE_PIXEL, 8'd170, 1'b0, 1'b0, '0},
        '{MODE_PIXEL, 8'd85,  1'b1, 1'b1, '{KIND_SUMMARY, 8'd85, 8'd170, 23'd0, 23'd1, 23'd0}},
        '{MODE_READ,  8'd170, 1'b0, 1'b1, '{KIND_READ,    8'd0,  8'd0,   23'd0, 23'd0, 23'd1}},
        '{MODE_READ,  8'd85,  1'b0, 1'b0, '0},
        '{MODE_READ,  8'd255, 1'b0, 1'b1, '{KIND_READ,    8'd0,  8'd0,   23'd0, 23'd0, 23'd0}},
        '{MODE_PIXEL, 8'd7,   1'b0, 1'b0, '0},
        '{MODE_PIXEL, 8'd7,   1'b0, 1'b0, '0},
        '{MODE_PIXEL, 8'd7,   1'b1, 1'b1, '{KIND_SUMMARY, 8'd7,  8'd7,   23'd0, 23'd3, 23'd0}},
        '{MODE_READ,  8'd7,   1'b0, 1'b1, '{KIND_READ,    8'd0,  8'd0,   23'd0, 23'd0, 23'd3}},
        '{MODE_PIXEL, 8'd1,   1'b0, 1'b0, '0},
        '{MODE_READ,  8'd1,   1'b0, 1'b1, '{KIND_READ,    8'd0,  8'd0,   23'd0, 23'd0, 23'd1}},
        '{MODE_PIXEL, 8'd254, 1'b1, 1'b0, '0},
        '{MODE_READ,  8'd254, 1'b0, 1'b0, '0}
    };

    // Work out the result of one accepted transaction and advance the
    // predicted state. A read leaves the frame alone; a pixel opens a frame if
    // none is open, counts into its bin, and on the last mark scans all bins.
    function automatic void predict_histogram(input logic mode, input pix_t value,
                                              input logic last_mark, output bit gives,
                                              output hist_result_t want);
        count_t lo_count;
        count_t hi_count;
        want  = '0;
        gives = 1'b0;
        if (mode == MODE_READ)
        begin
            want.kind      = KIND_READ;
            want.bin_count = tally[value];
            gives          = 1'b1;
        end
        else
        begin
            if (!frame_active)
            begin
                foreach (tally[i])
                    tally[i] = '0;
                frame_low    = '1;
                frame_high   = '0;
                frame_active = 1'b1;
            end
            // Hold the bin at full scale once it gets there.
            if (tally[value] != COUNT_MAX)
                tally[value] = tally[value] + 1'b1;
            if (value < frame_low)
                frame_low = value;
            if (value > frame_high)
                frame_high = value;
            if (last_mark)
            begin
                // The minimum starts at full scale, so a frame that fills
                // every bin reports its true smallest count.
                lo_count = COUNT_MAX;
                hi_count = '0;
                foreach (tally[i])
                begin
                    if (tally[i] < lo_count)
                        lo_count = tally[i];
                    if (tally[i] > hi_count)
                        hi_count = tally[i];
                end
                frame_active   = 1'b0;
                want.kind      = KIND_SUMMARY;
                want.min_pixel = frame_low;
                want.max_pixel = frame_high;
                want.min_count = lo_count;
                want.max_count = hi_count;
                gives          = 1'b1;
            end
        end
    endfunction

    // Drive one transaction on pix, with an occasional idle burst ahead of it,
    // and wait for its handshake. Sample ready at the falling edge, where it is
    // settled, so the acceptance decision never races the rising edge. On
    // acceptance, queue the result: the typed-in one if given, else the
    // predicted one.
    task automatic send_item(input logic mode, input pix_t value, input logic last_mark,
                             input bit known = 1'b0, input hist_result_t typed_want = '0);
        bit           gives;
        hist_result_t want;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            pix_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.mode  <= mode;
        pix_ch.pixel <= value;
        pix_ch.last  <= last_mark;
        @(negedge clk);
        while (!pix_ch.ready)
            @(negedge clk);
        @(posedge clk);
        predict_histogram(mode, value, last_mark, gives, want);
        if (gives)
            expected_results.push_back(known ? typed_want : want);
        if (mode == MODE_PIXEL)
            recent_pixel = value;
        items_sent++;
        calm = (items_sent >= ITEM_TARGET - CALM_ITEMS);
    endtask

    // Send a handful of bin reads between frames.
    task automatic send_reads();
        int n;
        n = $urandom_range(1, 3);
        repeat (n)
            send_item(MODE_READ, pix_t'($urandom), 1'b0);
    endtask

    // Send one well-formed frame with random content. Now and then send a
    // sweep frame that hits every bin at least once, so the smallest count is
    // above zero. Normal frames are short, since each ends in a full bin scan;
    // their pixels are fully random, drawn from a small pool, a single value
    // repeated, or the two extremes. Reads are mixed in, often of the pixel
    // just counted, to exercise forwarding on the bin store.
    task automatic send_frame();
        bit   sweep;
        int   len;
        int   style;
        int   extra;
        pix_t pool [3];
        pix_t stride;
        pix_t offset;
        pix_t value;
        sweep = (sweeps_done < 2) &&
                ($urandom_range(0, 29) == 0 || (frames_sent >= 12 && sweeps_done == 0));
        style = $urandom_range(0, 3);
        foreach (pool[i])
            pool[i] = pix_t'($urandom);
        if (sweep)
        begin
            stride = pix_t'($urandom_range(0, 127) * 2 + 1);
            offset = pix_t'($urandom);
            extra  = $urandom_range(0, 8);
            len    = BINS + extra;
            sweeps_done++;
        end
        else
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 12);
        end
        for (int k = 0; k < len; k++)
        begin
            if (sweep && k < BINS)
                value = pix_t'(k * stride + offset);
            else
            begin
                case (style)
                    0:       value = pix_t'($urandom);
                    1:       value = pool[$urandom_range(0, 2)];
                    2:       value = pool[0];
                    default: value = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                endcase
            end
            send_item(MODE_PIXEL, value, k == len - 1);
            if (k != len - 1 && $urandom_range(0, 5) == 0)
                send_item(MODE_READ, $urandom_range(0, 1) ? recent_pixel : pix_t'($urandom),
                          1'b0);
        end
        frames_sent++;
    endtask

    // Main sequence: reset, directed table, random frames and reads, drain.
    initial
    begin
        pix_ch.valid <= 1'b0;
        pix_ch.mode  <= MODE_PIXEL;
        pix_ch.pixel <= '0;
        pix_ch.last  <= 1'b0;
        foreach (tally[i])
            tally[i] = '0;
        frame_low    = '1;
        frame_high   = '0;
        frame_active = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_table[r])
            send_item(directed_table[r].mode, directed_table[r].pixel, directed_table[r].last,
                      directed_table[r].known, directed_table[r].want);

        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 3) == 0)
                send_reads();
            send_frame();
        end
        pix_ch.valid <= 1'b0;

        // Wait out every outstanding result, then watch a while for strays.
        // The watchdog ends the run if a result never arrives.
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_results.size() != 0)
            errors++;
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Stall the result side in random bursts; drop stalls for the last part
    // of the run.
    initial
    begin
        res_ch.ready <= 1'b1;
        @(posedge rst_n);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
        end
    end

    // Check each result transaction against the oldest expectation. Valid and
    // ready are stable at the falling edge and are taken at the next rising one.
    always @(negedge clk)
    begin : check_results
        hist_result_t got;
        hist_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.kind      = res_ch.kind;
            got.min_pixel = res_ch.min_pixel;
            got.max_pixel = res_ch.max_pixel;
            got.min_count = res_ch.min_count;
            got.max_count = res_ch.max_count;
            got.bin_count = res_ch.bin_count;
            if (expected_results.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: unexpected result kind=%0d min_pix=%0d max_pix=%0d min_cnt=%0d max_cnt=%0d bin_cnt=%0d",
                             $realtime, got.kind, got.min_pixel, got.max_pixel,
                             got.min_count, got.max_count, got.bin_count);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.kind !== want.kind || got.min_pixel !== want.min_pixel ||
                    got.max_pixel !== want.max_pixel || got.min_count !== want.min_count ||
                    got.max_count !== want.max_count || got.bin_count !== want.bin_count)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                    begin
                        $display("%0t: mismatch", $realtime);
                        $display("  expected kind=%0d min_pix=%0d max_pix=%0d min_cnt=%0d max_cnt=%0d bin_cnt=%0d",
                                 want.kind, want.min_pixel, want.max_pixel,
                                 want.min_count, want.max_count, want.bin_count);
                        $display("  actual   kind=%0d min_pix=%0d max_pix=%0d min_cnt=%0d max_cnt=%0d bin_cnt=%0d",
                                 got.kind, got.min_pixel, got.max_pixel,
                                 got.min_count, got.max_count, got.bin_count);
                    end
                end
            end
        end
    end

    // Watchdog: count cycles in which no transaction moves on either channel.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $realtime, WATCHDOG_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

endmodule

// File: filelist.f
design/ghe_pkg.sv
design/ghe_if.sv
design/ghe_bin_store.sv
design/gray_histogram_with_extrema.sv
tb/testbench.sv
